[hdl/msc_pkg.sv]
// Shared types, register codes, constants and fixed-point helpers of the motor speed controller.
package msc_pkg;

    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int Q_SHIFT = 16;

    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_KP    = 3'd1;
    localparam logic [2:0] REG_KI    = 3'd2;
    localparam logic [2:0] REG_DECAY = 3'd3;
    localparam logic [2:0] REG_KD    = 3'd4;
    localparam logic [2:0] REG_LIMIT = 3'd5;

    localparam logic [1:0] MODE_PI   = 2'd0;
    localparam logic [1:0] MODE_PD   = 2'd1;
    localparam logic [1:0] MODE_DIFF = 2'd2;
    localparam logic [1:0] MODE_HOLD = 2'd3;

    localparam logic signed [19:0] COEF_U1 = 20'sd115317;
    localparam logic signed [19:0] COEF_U2 = 20'sd49781;
    localparam logic signed [19:0] COEF_E0 = 20'sd187407;
    localparam logic signed [19:0] COEF_E1 = 20'sd287900;
    localparam logic signed [19:0] COEF_E2 = 20'sd107872;

    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] kp;
        logic signed [31:0] ki;
        logic [16:0]        decay;
        logic signed [31:0] kd;
        logic [14:0]        limit;
    } msc_cfg_t;

    typedef struct packed {
        logic signed [31:0] last_drive;
        logic signed [31:0] integral_sum;
        logic signed [31:0] derivative_term;
        logic signed [31:0] previous_measure;
        logic signed [31:0] drive_hist1;
        logic signed [31:0] drive_hist2;
        logic signed [31:0] err_hist1;
        logic signed [31:0] err_hist2;
    } msc_state_t;

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31])
            return s[32] ? SAT_MIN : SAT_MAX;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) - 33'(b);
        if (s[32] != s[31])
            return s[32] ? SAT_MIN : SAT_MAX;
        return s[31:0];
    endfunction

    // floor shift of the exact product, then clip to 32 bits
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [63:0] s;
        p = 64'(a) * 64'(b);
        s = p >>> Q_SHIFT;
        if (s > 64'(SAT_MAX))
            return SAT_MAX;
        if (s < 64'(SAT_MIN))
            return SAT_MIN;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] limit_q(input logic [14:0] lim);
        return {1'b0, lim, 16'b0};
    endfunction

endpackage

[hdl/msc_regs.sv]
// Configuration register bank of the motor speed controller behind the APB-style port.
module msc_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [msc_pkg::ADDR_W-1:0] paddr,
    input  logic [msc_pkg::DATA_W-1:0] pwdata,
    output logic [msc_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output msc_pkg::msc_cfg_t         cfg
);
    import msc_pkg::*;

    logic [1:0]         mode_reg;
    logic signed [31:0] kp_reg;
    logic signed [31:0] ki_reg;
    logic [16:0]        decay_reg;
    logic signed [31:0] kd_reg;
    logic [14:0]        limit_reg;
    logic               wr_en;
    logic [2:0]         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PI;
            kp_reg    <= 32'sd65536;
            ki_reg    <= '0;
            decay_reg <= '0;
            kd_reg    <= '0;
            limit_reg <= 15'd255;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MODE:  mode_reg  <= pwdata[1:0];
                REG_KP:    kp_reg    <= pwdata;
                REG_KI:    ki_reg    <= pwdata;
                REG_DECAY: decay_reg <= pwdata[16:0];
                REG_KD:    kd_reg    <= pwdata;
                REG_LIMIT: limit_reg <= pwdata[14:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MODE:  prdata = {30'b0, mode_reg};
            REG_KP:    prdata = kp_reg;
            REG_KI:    prdata = ki_reg;
            REG_DECAY: prdata = {15'b0, decay_reg};
            REG_KD:    prdata = kd_reg;
            REG_LIMIT: prdata = {17'b0, limit_reg};
            default:   prdata = '0;
        endcase
    end

    assign cfg = '{mode: mode_reg, kp: kp_reg, ki: ki_reg, decay: decay_reg,
                   kd: kd_reg, limit: limit_reg};

endmodule

[hdl/msc_law.sv]
// Control law datapath: drive value and next controller state for one sample.
module msc_law (
    input  msc_pkg::msc_cfg_t   cfg,
    input  msc_pkg::msc_state_t state,
    input  logic signed [31:0]  target,
    input  logic signed [31:0]  measured,
    output msc_pkg::msc_state_t state_next,
    output logic signed [31:0]  drive
);
    import msc_pkg::*;

    logic signed [31:0] lim;
    logic signed [31:0] err;
    logic signed [31:0] err_int;
    logic signed [31:0] dm;
    logic signed [31:0] prop;
    logic signed [31:0] mul_x;
    logic signed [31:0] mul_y;
    logic signed [31:0] shared_prod;
    logic signed [31:0] kd_prod;
    logic signed [31:0] integral_new;
    logic signed [31:0] dterm_new;
    logic signed [55:0] acc;
    logic signed [55:0] acc_q;
    logic signed [31:0] diff_out;

    assign lim  = limit_q(cfg.limit);
    assign err  = sub_sat(target, measured);
    assign dm   = sub_sat(measured, state.previous_measure);
    assign prop = qmul(cfg.kp, err);

    always_comb
    begin
        err_int = err;
        if (state.last_drive >= lim && target > measured)
            err_int = '0;
        else if (state.last_drive <= -lim && target < measured)
            err_int = '0;
    end

    // share one multiplier between the integrator and the derivative filter
    assign mul_x        = (cfg.mode == MODE_PI) ? cfg.ki : {15'b0, cfg.decay};
    assign mul_y        = (cfg.mode == MODE_PI) ? err_int : state.derivative_term;
    assign shared_prod  = qmul(mul_x, mul_y);
    assign kd_prod      = qmul(cfg.kd, dm);
    assign integral_new = add_sat(state.integral_sum, shared_prod);
    assign dterm_new    = sub_sat(shared_prod, kd_prod);

    assign acc = 56'(COEF_U1) * 56'(state.drive_hist1)
               - 56'(COEF_U2) * 56'(state.drive_hist2)
               + 56'(COEF_E0) * 56'(err)
               - 56'(COEF_E1) * 56'(state.err_hist1)
               + 56'(COEF_E2) * 56'(state.err_hist2);
    assign acc_q = acc >>> Q_SHIFT;

    always_comb
    begin
        priority if (acc_q > 56'(lim))
            diff_out = lim;
        else if (acc_q < 56'(-lim))
            diff_out = -lim;
        else
            diff_out = acc_q[31:0];
    end

    always_comb
    begin
        state_next = state;
        drive      = state.last_drive;
        unique case (cfg.mode)
            MODE_PI:
            begin
                drive                   = add_sat(prop, integral_new);
                state_next.integral_sum = integral_new;
                state_next.last_drive   = drive;
            end
            MODE_PD:
            begin
                drive                       = add_sat(prop, dterm_new);
                state_next.derivative_term  = dterm_new;
                state_next.previous_measure = measured;
                state_next.last_drive       = drive;
            end
            MODE_DIFF:
            begin
                drive                  = diff_out;
                state_next.drive_hist1 = diff_out;
                state_next.drive_hist2 = state.drive_hist1;
                state_next.err_hist1   = err;
                state_next.err_hist2   = state.err_hist1;
                state_next.last_drive  = diff_out;
            end
            MODE_HOLD:
            begin
                drive = state.last_drive;
            end
        endcase
    end

endmodule

[hdl/motor_speed_controller_core.sv]
// Top level of the motor speed controller: sample register, control law, state and drive register.
// Each accepted sample (target, measured) yields one drive beat. A sample is registered on
// acceptance and its drive is loaded into the output register when the sample register advances,
// which a stalled drive can hold back; one sample is taken every cycle unless a stall holds it.
// The control state (integrator, derivative filter, histories) updates in the same cycle
// the law is evaluated. The output register holds a stalled drive while the sample register takes
// one more beat; configuration is read and written through the APB-style port without wait states.
module motor_speed_controller_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [msc_pkg::ADDR_W-1:0] paddr,
    input  logic [msc_pkg::DATA_W-1:0] pwdata,
    output logic [msc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic signed [31:0]         target,
    input  logic signed [31:0]         measured,
    output logic                       drive_valid,
    input  logic                       drive_stall,
    output logic signed [31:0]         drive
);
    import msc_pkg::*;

    msc_cfg_t           cfg;
    msc_state_t         state_reg;
    msc_state_t         state_next;
    logic               s1_valid_reg;
    logic signed [31:0] s1_target_reg;
    logic signed [31:0] s1_measured_reg;
    logic               drive_valid_reg;
    logic signed [31:0] drive_reg;
    logic signed [31:0] drive_next;
    logic               advance;
    logic               accept;

    msc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    msc_law u_law (
        .cfg        (cfg),
        .state      (state_reg),
        .target     (s1_target_reg),
        .measured   (s1_measured_reg),
        .state_next (state_next),
        .drive      (drive_next)
    );

    assign advance      = s1_valid_reg && (!drive_valid_reg || !drive_stall);
    assign sample_stall = s1_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;
    assign drive_valid  = drive_valid_reg;
    assign drive        = drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            drive_valid_reg <= 1'b0;
            state_reg       <= '0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                drive_valid_reg <= 1'b1;
            else if (!drive_stall)
                drive_valid_reg <= 1'b0;

            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_target_reg   <= target;
            s1_measured_reg <= measured;
        end
        if (advance)
            drive_reg <= drive_next;
    end

    a_hold_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cfg.mode == MODE_HOLD) |=> state_reg == $past(state_reg))
        else $error("hold mode changed controller state");

    a_diff_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cfg.mode == MODE_DIFF) |=>
        (drive_reg <= $past(limit_q(cfg.limit)) && drive_reg >= -$past(limit_q(cfg.limit))))
        else $error("difference equation drive beyond limit");

    a_drive_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> drive_valid_reg && drive_reg == state_reg.last_drive)
        else $error("drive beat differs from stored last drive");

    a_diff_history: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cfg.mode == MODE_DIFF) |=> state_reg.drive_hist1 == drive_reg)
        else $error("drive history not advanced");

    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && drive_valid_reg && drive_stall) |-> sample_stall && !advance)
        else $error("sample taken while both stages are blocked");

endmodule

[dv/motor_speed_controller_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the motor speed controller: tracks register writes, predicts each drive, compares.
module motor_speed_controller_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [msc_pkg::ADDR_W-1:0] paddr,
    input  logic [msc_pkg::DATA_W-1:0] pwdata,
    input  logic                       sample_valid,
    input  logic                       sample_stall,
    input  logic signed [31:0]         target,
    input  logic signed [31:0]         measured,
    input  logic                       drive_valid,
    input  logic                       drive_stall,
    input  logic signed [31:0]         drive,
    output int                         mismatches,
    output int                         outstanding
);
    import msc_pkg::*;

    localparam longint W_U1 = 115317;
    localparam longint W_U2 = 49781;
    localparam longint W_E0 = 187407;
    localparam longint W_E1 = 287900;
    localparam longint W_E2 = 107872;
    localparam longint CEIL32 = 64'sd2147483647;
    localparam longint FLOOR32 = -64'sd2147483648;

    logic [1:0]         cfg_mode;
    logic signed [31:0] cfg_kp;
    logic signed [31:0] cfg_ki;
    logic [16:0]        cfg_decay;
    logic signed [31:0] cfg_kd;
    logic [14:0]        cfg_limit;

    logic signed [31:0] prior_drive;
    logic signed [31:0] integ_acc;
    logic signed [31:0] deriv_state;
    logic signed [31:0] prior_meas;
    logic signed [31:0] drive_d1;
    logic signed [31:0] drive_d2;
    logic signed [31:0] err_d1;
    logic signed [31:0] err_d2;

    logic signed [31:0] drives_due[$];
    logic signed [31:0] predicted;
    logic signed [31:0] wanted;

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > CEIL32)
            return 32'sh7fffffff;
        if (v < FLOOR32)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fixmul(input longint a, input longint b);
        return clip32((a * b) >>> 16);
    endfunction

    task automatic advance_controller(input logic signed [31:0] tgt,
                                      input logic signed [31:0] meas,
                                      output logic signed [31:0] next_drive);
        longint lim;
        longint acc;
        logic signed [31:0] err;
        logic signed [31:0] err_in;
        logic signed [31:0] delta;
        lim = longint'(cfg_limit) * 65536;
        err = clip32(longint'(tgt) - longint'(meas));
        next_drive = prior_drive;
        case (cfg_mode)
            MODE_PI:
            begin
                err_in = err;
                if (longint'(prior_drive) >= lim && tgt > meas)
                    err_in = 0;
                else if (longint'(prior_drive) <= -lim && tgt < meas)
                    err_in = 0;
                integ_acc = clip32(longint'(integ_acc) + longint'(fixmul(cfg_ki, err_in)));
                next_drive = clip32(longint'(fixmul(cfg_kp, err)) + longint'(integ_acc));
                prior_drive = next_drive;
            end
            MODE_PD:
            begin
                delta = clip32(longint'(meas) - longint'(prior_meas));
                deriv_state = clip32(longint'(fixmul(cfg_decay, deriv_state))
                                     - longint'(fixmul(cfg_kd, delta)));
                next_drive = clip32(longint'(fixmul(cfg_kp, err)) + longint'(deriv_state));
                prior_meas = meas;
                prior_drive = next_drive;
            end
            MODE_DIFF:
            begin
                acc = W_U1 * longint'(drive_d1) - W_U2 * longint'(drive_d2)
                    + W_E0 * longint'(err) - W_E1 * longint'(err_d1)
                    + W_E2 * longint'(err_d2);
                acc = acc >>> 16;
                if (acc > lim)
                    acc = lim;
                else if (acc < -lim)
                    acc = -lim;
                next_drive = acc[31:0];
                drive_d2 = drive_d1;
                err_d2 = err_d1;
                drive_d1 = next_drive;
                err_d1 = err;
                prior_drive = next_drive;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        $display("%0t: drive mismatch (%s): got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_mode = MODE_PI;
            cfg_kp = 32'sd65536;
            cfg_ki = 0;
            cfg_decay = 0;
            cfg_kd = 0;
            cfg_limit = 15'd255;
            prior_drive = 0;
            integ_acc = 0;
            deriv_state = 0;
            prior_meas = 0;
            drive_d1 = 0;
            drive_d2 = 0;
            err_d1 = 0;
            err_d2 = 0;
            drives_due.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_MODE:  cfg_mode = pwdata[1:0];
                    REG_KP:    cfg_kp = pwdata;
                    REG_KI:    cfg_ki = pwdata;
                    REG_DECAY: cfg_decay = pwdata[16:0];
                    REG_KD:    cfg_kd = pwdata;
                    REG_LIMIT: cfg_limit = pwdata[14:0];
                    default:   ;
                endcase
            end
            if (sample_valid && !sample_stall)
            begin
                advance_controller(target, measured, predicted);
                drives_due.push_back(predicted);
            end
            if (drive_valid && !drive_stall)
            begin
                if (drives_due.size() == 0)
                    report_mismatch("no sample outstanding", drive, 0);
                else
                begin
                    wanted = drives_due.pop_front();
                    if (drive !== wanted)
                        report_mismatch("value", drive, wanted);
                end
            end
            outstanding <= drives_due.size();
        end
    end

endmodule

[dv/tb_motor_speed_controller_core.sv]
`timescale 1ns / 100ps
// Testbench top for the motor speed controller: clock, reset, register setup, samples, verdict.
module tb_motor_speed_controller_core;
    import msc_pkg::*;

    localparam logic signed [31:0] FULL_POS = 32'sh7fffffff;
    localparam logic signed [31:0] FULL_NEG = 32'sh80000000;
    localparam logic signed [31:0] UNIT     = 32'sh00010000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              sample_valid = 1'b0;
    logic              sample_stall;
    logic signed [31:0] target = '0;
    logic signed [31:0] measured = '0;
    logic              drive_valid;
    logic              drive_stall = 1'b0;
    logic signed [31:0] drive;

    int         mismatches;
    int         outstanding;
    bit         quiet = 1'b0;
    logic [1:0] cur_mode = MODE_PI;
    int         settings_applied = 0;
    int         per_mode[4] = '{0, 0, 0, 0};

    motor_speed_controller_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .target       (target),
        .measured     (measured),
        .drive_valid  (drive_valid),
        .drive_stall  (drive_stall),
        .drive        (drive)
    );

    motor_speed_controller_checker drive_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .target       (target),
        .measured     (measured),
        .drive_valid  (drive_valid),
        .drive_stall  (drive_stall),
        .drive        (drive),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        drive_stall <= !quiet && ($urandom_range(0, 99) < 31);

    function automatic logic [31:0] rand_level();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        if (pick < 60)
            return $urandom();
        if (pick < 75)
            return $urandom_range(0, 1) ? FULL_POS - $urandom_range(0, 255)
                                        : FULL_NEG + $urandom_range(0, 255);
        return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endfunction

    function automatic logic [31:0] rand_gain();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        if (pick < 85)
            return $urandom();
        case ($urandom_range(0, 4))
            0:       return FULL_POS;
            1:       return FULL_NEG;
            2:       return 0;
            3:       return UNIT;
            default: return -UNIT;
        endcase
    endfunction

    task automatic send_sample(input logic signed [31:0] tgt, input logic signed [31:0] meas);
        while (!quiet && $urandom_range(0, 99) < 31)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        target <= tgt;
        measured <= meas;
        do
            @(posedge clk);
        while (sample_stall);
        per_mode[cur_mode]++;
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [1:0] md, input logic [31:0] kp,
                                  input logic [31:0] ki, input logic [16:0] decay,
                                  input logic [31:0] kd, input logic [14:0] lim);
        wait_drained();
        write_reg(REG_MODE, 32'(md));
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_DECAY, 32'(decay));
        write_reg(REG_KD, kd);
        write_reg(REG_LIMIT, 32'(lim));
        cur_mode = md;
        settings_applied++;
    endtask

    initial
    begin
        logic [1:0]  md;
        logic [16:0] decay;
        logic [14:0] lim;
        logic [31:0] tgt;
        logic [31:0] meas;
        int unsigned pick;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(FULL_POS, FULL_NEG);
        send_sample(FULL_NEG, FULL_POS);
        send_sample(0, 0);
        send_sample(FULL_POS, FULL_POS);
        send_sample(FULL_NEG, FULL_NEG);
        send_sample(1, -1);

        apply_settings(MODE_PI, UNIT, FULL_POS, 17'd0, 0, 15'd0);
        send_sample(UNIT, 0);
        send_sample(UNIT, 0);
        send_sample(0, UNIT);
        send_sample(0, UNIT);
        send_sample(FULL_POS, FULL_NEG);

        apply_settings(MODE_PD, FULL_NEG, 0, 17'd131071, FULL_POS, 15'd32767);
        send_sample(0, FULL_POS);
        send_sample(0, FULL_NEG);
        send_sample(5 * UNIT, 3 * UNIT);
        send_sample(0, 0);

        apply_settings(MODE_DIFF, 0, 0, 17'd65536, 0, 15'd32767);
        send_sample(FULL_POS, FULL_NEG);
        send_sample(FULL_NEG, FULL_POS);
        send_sample(UNIT, 0);
        send_sample(0, 0);

        apply_settings(MODE_DIFF, UNIT, UNIT, 17'd0, UNIT, 15'd0);
        send_sample(UNIT, 0);

        apply_settings(MODE_HOLD, UNIT, UNIT, 17'd65536, UNIT, 15'd255);
        send_sample(FULL_POS, 0);
        send_sample(0, FULL_POS);

        for (int ph = 0; ph < 12; ph++)
        begin
            pick = $urandom_range(0, 9);
            md = (pick < 3) ? MODE_PI : (pick < 6) ? MODE_PD : (pick < 9) ? MODE_DIFF : MODE_HOLD;
            pick = $urandom_range(0, 99);
            decay = (pick < 60) ? 17'($urandom_range(0, 65536))
                  : (pick < 80) ? ($urandom_range(0, 1) ? 17'd65536 : 17'd0)
                  : 17'($urandom_range(65537, 131071));
            pick = $urandom_range(0, 99);
            lim = (pick < 50) ? 15'($urandom_range(0, 32767))
                : (pick < 75) ? ($urandom_range(0, 1) ? 15'd32767 : 15'd0)
                : 15'($urandom_range(1, 1000));
            apply_settings(md, rand_gain(), rand_gain(), decay, rand_gain(), lim);
            quiet = (ph == 4 || ph == 5);
            for (int k = 0; k < 120; k++)
            begin
                if (k == 60 || $urandom_range(0, 299) == 0)
                    wait_drained();
                tgt = rand_level();
                if ($urandom_range(0, 1))
                    meas = tgt + ($urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
                else
                    meas = rand_level();
                send_sample(tgt, meas);
            end
        end
        quiet = 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        $write("Sent %0d samples under %0d register settings: ",
               per_mode[0] + per_mode[1] + per_mode[2] + per_mode[3], settings_applied);
        $display("PI %0d, PD %0d, difference %0d, hold %0d.",
                 per_mode[0], per_mode[1], per_mode[2], per_mode[3]);
        $display("Settings spanned limits 0 and 32767, decay above unity and full-scale gains.");
        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Timeout with %0d drives outstanding", outstanding);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
